[design/lfu_pcd_pkg.sv]
// Package for the LFU page cache directory: the search token that travels
// along the row of slot cells, the write command for a slot, and shared codes.
// No dependencies.
package lfu_pcd_pkg;

  localparam int unsigned PageW  = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned CapW   = 5;
  // Index and occupancy fields are sized for the largest supported row of 256 cells.
  localparam int unsigned IdxW   = 8;
  localparam int unsigned OccW   = 9;

  typedef enum logic [1:0] {
    ActLookup = 2'd0,
    ActInsert = 2'd1,
    ActUpdate = 2'd2,
    ActRemove = 2'd3
  } action_e;

  typedef struct packed {
    logic              match_found;
    logic [IdxW-1:0]   match_idx;
    logic [CountW-1:0] match_count;
    logic [OccW-1:0]   occupancy;
    logic              min_valid;
    logic [IdxW-1:0]   min_idx;
    logic [CountW-1:0] min_count;
    logic [PageW-1:0]  min_page;
    logic              free_found;
    logic [IdxW-1:0]   free_idx;
  } scan_tok_t;

  typedef struct packed {
    logic              en;
    logic [IdxW-1:0]   idx;
    logic              set_page;
    logic              valid;
    logic [PageW-1:0]  page;
    logic [CountW-1:0] count;
  } slot_cmd_t;

endpackage

[design/lfu_pcd_cell.sv]
// One slot of the directory: holds a page, its count and a valid bit, and
// advances the search token by one position per cycle.
// Depends on lfu_pcd_pkg.
module lfu_pcd_cell import lfu_pcd_pkg::*; #(
  parameter int unsigned CellIdx = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [PageW-1:0] query_page_i,
  input  scan_tok_t        tok_i,
  output scan_tok_t        tok_o,
  input  slot_cmd_t        cmd_i
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic              valid_q;
  logic [PageW-1:0]  page_q;
  logic [CountW-1:0] count_q;
  scan_tok_t         tok_d;
  scan_tok_t         tok_q;
  logic              sel;

  assign sel = cmd_i.en && (cmd_i.idx == MyIdx);

  always_comb begin
    tok_d = tok_i;
    if (!tok_i.match_found && valid_q && (page_q == query_page_i) &&
        (query_page_i != '0)) begin
      tok_d.match_found = 1'b1;
      tok_d.match_idx   = MyIdx;
      tok_d.match_count = count_q;
    end
    tok_d.occupancy = tok_i.occupancy + OccW'(valid_q);
    if (valid_q && (!tok_i.min_valid || (count_q < tok_i.min_count) ||
        ((count_q == tok_i.min_count) && (page_q < tok_i.min_page)))) begin
      tok_d.min_valid = 1'b1;
      tok_d.min_idx   = MyIdx;
      tok_d.min_count = count_q;
      tok_d.min_page  = page_q;
    end
    if (!tok_i.free_found && !valid_q) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sel) begin
      valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (sel) begin
      count_q <= cmd_i.count;
      if (cmd_i.set_page) begin
        page_q <= cmd_i.page;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

[design/lfu_pcd_top.sv]
// The search token walks the row of slot cells one cell per cycle before the commit, and
// a new transaction is not taken until the previous one has committed.
// A finished result waits in an output register while the next item is taken.
// Reset empties every slot, clears the highest page and sets capacity to 16.
// Top level of the LFU page cache directory; depends on lfu_pcd_pkg, lfu_pcd_cell.
module lfu_page_cache_directory_top import lfu_pcd_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wr_en_i,
  input  logic [CapW-1:0]   cfg_wr_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        action_i,
  input  logic [PageW-1:0]  page_number_i,
  input  logic [CountW-1:0] initial_count_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              found_o,
  output logic              evicted_valid_o,
  output logic [PageW-1:0]  evicted_page_o,
  output logic [CountW-1:0] access_count_o,
  output logic [PageW-1:0]  highest_page_o
);

  localparam int unsigned CntW = $clog2(NUM_SLOTS);
  localparam logic [CntW-1:0] LastCnt = CntW'(NUM_SLOTS - 1);
  localparam logic [OccW-1:0] MaxCap  = OccW'(NUM_SLOTS);

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StScan   = 3'b010,
    StCommit = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CapW-1:0]   cap_q;
  action_e           act_q;
  logic [PageW-1:0]  page_q;
  logic [CountW-1:0] init_q;
  logic [PageW-1:0]  hi_q, hi_d;
  logic              out_valid_q;
  logic              found_q, ev_valid_q;
  logic [PageW-1:0]  ev_page_q, hi_out_q;
  logic [CountW-1:0] acc_q;

  scan_tok_t         tok [NUM_SLOTS+1];
  scan_tok_t         res;
  slot_cmd_t         cmd;
  logic              accept, commit_go;
  logic [OccW-1:0]   cap_ext, eff_cap;
  logic              ev_valid;
  logic [PageW-1:0]  ev_page;
  logic [CountW-1:0] acc;

  assign tok[0] = '0;
  assign res    = tok[NUM_SLOTS];

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    lfu_pcd_cell #(.CellIdx(g)) u_cell (
      .clk_i,
      .rst_ni,
      .query_page_i (page_q),
      .tok_i        (tok[g]),
      .tok_o        (tok[g+1]),
      .cmd_i        (cmd)
    );
  end

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign commit_go = (state_q == StCommit) && (!out_valid_q || !out_stall_i);

  assign cap_ext = OccW'(cap_q);
  assign eff_cap = (cap_ext == '0) ? OccW'(1) : ((cap_ext > MaxCap) ? MaxCap : cap_ext);

  always_comb begin
    cmd      = '0;
    ev_valid = 1'b0;
    ev_page  = '0;
    acc      = '0;
    hi_d     = hi_q;
    unique case (act_q)
      ActLookup: begin
        if (res.match_found) begin
          acc = (res.match_count == '1) ? res.match_count : res.match_count + 1'b1;
          cmd.en    = 1'b1;
          cmd.idx   = res.match_idx;
          cmd.valid = 1'b1;
          cmd.count = acc;
        end
      end
      ActInsert: begin
        if (res.match_found) begin
          acc = res.match_count;
        end else if (page_q != '0) begin
          cmd.en       = 1'b1;
          cmd.valid    = 1'b1;
          cmd.set_page = 1'b1;
          cmd.page     = page_q;
          cmd.count    = init_q;
          acc          = init_q;
          if (res.occupancy >= eff_cap) begin
            cmd.idx  = res.min_idx;
            ev_valid = 1'b1;
            ev_page  = res.min_page;
          end else begin
            cmd.idx = res.free_idx;
          end
          if (page_q > hi_q) begin
            hi_d = page_q;
          end
        end
      end
      ActUpdate: begin
        if (res.match_found) begin
          cmd.en    = 1'b1;
          cmd.idx   = res.match_idx;
          cmd.valid = 1'b1;
          cmd.count = init_q;
          acc       = init_q;
        end
      end
      ActRemove: begin
        if (res.match_found) begin
          cmd.en    = 1'b1;
          cmd.idx   = res.match_idx;
          cmd.valid = 1'b0;
          cmd.count = '0;
        end
      end
      default: ;
    endcase
    if (!commit_go) begin
      cmd.en = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StScan;
          cnt_d   = '0;
        end
      end
      StScan: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        if (commit_go) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      cap_q       <= CapW'(16);
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_wr_en_i) begin
        cap_q <= cfg_wr_data_i;
      end
      if (commit_go) begin
        hi_q        <= hi_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= action_e'(action_i);
      page_q <= page_number_i;
      init_q <= initial_count_i;
    end
    if (commit_go) begin
      found_q    <= res.match_found;
      ev_valid_q <= ev_valid;
      ev_page_q  <= ev_page;
      acc_q      <= acc;
      hi_out_q   <= hi_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign access_count_o  = acc_q;
  assign highest_page_o  = hi_out_q;

endmodule

[dv/lfu_page_cache_directory_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the LFU page cache directory. It mirrors the directory from the accepted
// input transactions and capacity writes, and checks every result transaction in order.
// Depends on lfu_pcd_pkg.
module lfu_page_cache_directory_checker import lfu_pcd_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wr_en_i,
  input  logic [CapW-1:0]   cfg_wr_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [1:0]        action_i,
  input  logic [PageW-1:0]  page_number_i,
  input  logic [CountW-1:0] initial_count_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic              found_i,
  input  logic              evicted_valid_i,
  input  logic [PageW-1:0]  evicted_page_i,
  input  logic [CountW-1:0] access_count_i,
  input  logic [PageW-1:0]  highest_page_i,
  input  logic              end_check_i,
  output int                pending_o,
  output int                errors_o,
  output int                checked_o,
  output int                evictions_o
);

  typedef struct packed {
    logic              found;
    logic              ev_valid;
    logic [PageW-1:0]  ev_page;
    logic [CountW-1:0] acc;
    logic [PageW-1:0]  highest;
  } dir_answer_t;

  logic              mirror_valid [NUM_SLOTS];
  logic [PageW-1:0]  mirror_page [NUM_SLOTS];
  logic [CountW-1:0] mirror_count [NUM_SLOTS];
  logic [PageW-1:0]  mirror_highest;
  logic [CapW-1:0]   mirror_capacity;
  dir_answer_t       answer_q[$];

  function automatic dir_answer_t apply_access(input action_e act,
                                               input logic [PageW-1:0] pg,
                                               input logic [CountW-1:0] cnt);
    dir_answer_t ans;
    int hit, victim, target, occupied, limit;
    ans = '0;
    hit = -1;
    victim = -1;
    target = -1;
    occupied = 0;
    if (pg != '0) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (hit < 0 && mirror_valid[i] && mirror_page[i] == pg) hit = i;
      end
    end
    ans.found = (hit >= 0);
    case (act)
      ActLookup: begin
        if (hit >= 0) begin
          if (mirror_count[hit] != '1) mirror_count[hit] = mirror_count[hit] + 1'b1;
          ans.acc = mirror_count[hit];
        end
      end
      ActInsert: begin
        if (hit >= 0) begin
          ans.acc = mirror_count[hit];
        end else if (pg != '0) begin
          limit = (mirror_capacity == 0) ? 1 :
                  (mirror_capacity > NUM_SLOTS) ? NUM_SLOTS : int'(mirror_capacity);
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (mirror_valid[i]) occupied++;
          end
          if (occupied >= limit) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (mirror_valid[i] && (victim < 0 || mirror_count[i] < mirror_count[victim] ||
                  (mirror_count[i] == mirror_count[victim] &&
                   mirror_page[i] < mirror_page[victim]))) victim = i;
            end
            ans.ev_valid = 1'b1;
            ans.ev_page  = mirror_page[victim];
            target = victim;
          end else begin
            for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
              if (!mirror_valid[i]) target = i;
            end
          end
          mirror_valid[target] = 1'b1;
          mirror_page[target]  = pg;
          mirror_count[target] = cnt;
          ans.acc = cnt;
          if (pg > mirror_highest) mirror_highest = pg;
        end
      end
      ActUpdate: begin
        if (hit >= 0) begin
          mirror_count[hit] = cnt;
          ans.acc = cnt;
        end
      end
      default: begin
        if (hit >= 0) begin
          mirror_valid[hit] = 1'b0;
          mirror_count[hit] = '0;
        end
      end
    endcase
    ans.highest = mirror_highest;
    return ans;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors_o < 40) $display("%0t ns checker: %s", $time, msg);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dir_answer_t want;
    dir_answer_t got;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        mirror_valid[i] = 1'b0;
        mirror_page[i]  = '0;
        mirror_count[i] = '0;
      end
      mirror_highest  = '0;
      mirror_capacity = CapW'(16);
      answer_q.delete();
      pending_o   = 0;
      errors_o    = 0;
      checked_o   = 0;
      evictions_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result transaction with no input transaction waiting");
        end else begin
          want = answer_q.pop_front();
          got  = {found_i, evicted_valid_i, evicted_page_i, access_count_i, highest_page_i};
          checked_o++;
          if (got.found !== want.found)
            report_mismatch($sformatf("found %b, expected %b", got.found, want.found));
          if (got.ev_valid !== want.ev_valid)
            report_mismatch($sformatf("evicted_valid %b, expected %b",
                                      got.ev_valid, want.ev_valid));
          if (got.ev_page !== want.ev_page)
            report_mismatch($sformatf("evicted_page %0d, expected %0d",
                                      got.ev_page, want.ev_page));
          if (got.acc !== want.acc)
            report_mismatch($sformatf("access_count %0d, expected %0d", got.acc, want.acc));
          if (got.highest !== want.highest)
            report_mismatch($sformatf("highest_page %0d, expected %0d",
                                      got.highest, want.highest));
        end
      end
      if (cfg_wr_en_i) mirror_capacity = cfg_wr_data_i;
      if (in_valid_i && !in_stall_i) begin
        want = apply_access(action_e'(action_i), page_number_i, initial_count_i);
        if (want.ev_valid) evictions_o++;
        answer_q.push_back(want);
      end
      if (end_check_i) begin
        while (answer_q.size() > 0) begin
          report_mismatch("expected result transaction never arrived");
          void'(answer_q.pop_front());
        end
      end
      pending_o = answer_q.size();
    end
  end

endmodule

[dv/lfu_page_cache_directory_top_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the LFU page cache directory: drives directed and random transactions
// with random gaps and stalls, and reports the verdict.
// Depends on lfu_pcd_pkg, lfu_page_cache_directory_top and lfu_page_cache_directory_checker.
module lfu_page_cache_directory_top_tb;
  import lfu_pcd_pkg::*;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int Settle     = NUM_SLOTS + 2;
  localparam int PhaseItems = 54;
  localparam int PoolSize   = 24;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_wr_en_i;
  logic [CapW-1:0]   cfg_wr_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        action_i;
  logic [PageW-1:0]  page_number_i;
  logic [CountW-1:0] initial_count_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              found_o;
  logic              evicted_valid_o;
  logic [PageW-1:0]  evicted_page_o;
  logic [CountW-1:0] access_count_o;
  logic [PageW-1:0]  highest_page_o;
  logic              end_check;
  logic              calm_in;
  logic [PageW-1:0]  page_pool [PoolSize];
  int                pool_span;
  int                pending, error_total, checked_total, eviction_total;
  int                sent_items, cap_writes;

  always #5ns clk_i = ~clk_i;

  lfu_page_cache_directory_top #(.NUM_SLOTS(NUM_SLOTS)) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .page_number_i   (page_number_i),
    .initial_count_i (initial_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .access_count_o  (access_count_o),
    .highest_page_o  (highest_page_o)
  );

  lfu_page_cache_directory_checker #(.NUM_SLOTS(NUM_SLOTS)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .action_i        (action_i),
    .page_number_i   (page_number_i),
    .initial_count_i (initial_count_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_i         (found_o),
    .evicted_valid_i (evicted_valid_o),
    .evicted_page_i  (evicted_page_o),
    .access_count_i  (access_count_o),
    .highest_page_i  (highest_page_o),
    .end_check_i     (end_check),
    .pending_o       (pending),
    .errors_o        (error_total),
    .checked_o       (checked_total),
    .evictions_o     (eviction_total)
  );

  function automatic int gap_length(input logic calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_access(input action_e act, input logic [PageW-1:0] pg,
                             input logic [CountW-1:0] cnt);
    int gap;
    gap = gap_length(calm_in);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    page_number_i   <= pg;
    initial_count_i <= cnt;
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
  endtask

  task automatic send_random_access;
    int r;
    action_e act;
    logic [PageW-1:0] pg;
    logic [CountW-1:0] cnt;
    r = $urandom_range(0, 99);
    act = (r < 35) ? ActInsert : (r < 70) ? ActLookup : (r < 85) ? ActUpdate : ActRemove;
    r = $urandom_range(0, 99);
    pg = (r < 5) ? '0 : (r < 15) ? PageW'($urandom_range(0, 65535)) :
         page_pool[$urandom_range(0, pool_span - 1)];
    r = $urandom_range(0, 99);
    cnt = (r < 40) ? CountW'($urandom_range(0, 3)) :
          (r < 55) ? CountW'($urandom_range(65533, 65535)) :
          CountW'($urandom_range(0, 65535));
    send_access(act, pg, cnt);
  endtask

  task automatic drain_results;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] value);
    drain_results();
    repeat (Settle) @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
    cap_writes++;
  endtask

  initial begin : output_side
    int run;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      run = gap_length(1'b0);
      if (run > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (run - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      if ($urandom_range(0, 9) == 0) run = $urandom_range(100, 300);
      else run = $urandom_range(1, 6);
      repeat (run) @(negedge clk_i);
    end
  end

  initial begin : watchdog
    #5ms;
    $display("lfu_page_cache_directory_top_tb: errors");
    $finish;
  end

  initial begin : stimulus
    logic [CapW-1:0] phase_caps [8];
    phase_caps      = '{5'd31, 5'd16, 5'd1, 5'd8, 5'd0, 5'd3, 5'd17, 5'd12};
    rst_ni          = 1'b0;
    cfg_wr_en_i     = 1'b0;
    cfg_wr_data_i   = '0;
    in_valid_i      = 1'b0;
    action_i        = ActLookup;
    page_number_i   = '0;
    initial_count_i = '0;
    end_check       = 1'b0;
    calm_in         = 1'b0;
    sent_items      = 0;
    cap_writes      = 0;
    pool_span       = PoolSize;
    page_pool[0]    = 16'd1;
    page_pool[1]    = 16'hFFFF;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_capacity(5'd2);
    send_access(ActLookup, 16'd0, 16'd4);
    send_access(ActInsert, 16'd0, 16'd4);
    send_access(ActUpdate, 16'd0, 16'd4);
    send_access(ActRemove, 16'd0, 16'd4);
    send_access(ActLookup, 16'd5, 16'd0);
    send_access(ActUpdate, 16'd5, 16'd1);
    send_access(ActRemove, 16'd5, 16'd0);
    send_access(ActInsert, 16'hFFFF, 16'hFFFE);
    send_access(ActLookup, 16'hFFFF, 16'd0);
    send_access(ActLookup, 16'hFFFF, 16'd0);
    send_access(ActInsert, 16'd1, 16'd0);
    send_access(ActInsert, 16'd1, 16'd77);
    send_access(ActInsert, 16'd7, 16'd0);
    send_access(ActInsert, 16'd3, 16'd0);
    send_access(ActUpdate, 16'hFFFF, 16'd0);
    send_access(ActInsert, 16'd9, 16'd5);
    send_access(ActUpdate, 16'd9, 16'hFFFF);
    send_access(ActRemove, 16'd9, 16'd0);
    send_access(ActRemove, 16'd9, 16'd0);
    send_access(ActInsert, 16'd2, 16'd8);
    write_capacity(5'd0);
    send_access(ActInsert, 16'd4, 16'd1);
    send_access(ActInsert, 16'd6, 16'd9);

    for (int p = 0; p < 8; p++) begin
      write_capacity(phase_caps[p]);
      calm_in   = (p % 3 == 2);
      pool_span = $urandom_range(4, PoolSize);
      for (int i = 2; i < PoolSize; i++) page_pool[i] = PageW'($urandom_range(1, 65535));
      for (int k = 0; k < PhaseItems; k++) begin
        if (k == PhaseItems / 2 && p % 3 == 1) drain_results();
        send_random_access();
      end
    end

    drain_results();
    repeat (Settle) @(negedge clk_i);
    end_check = 1'b1;
    @(negedge clk_i);
    end_check = 1'b0;
    @(negedge clk_i);
    $display("Sent %0d transactions under %0d capacity settings, from zero to thirty-one.",
             sent_items, cap_writes);
    $display("Checked %0d result transactions, %0d of which evicted a page.",
             checked_total, eviction_total);
    if (error_total == 0) begin
      $display("lfu_page_cache_directory_top_tb: clean");
    end else begin
      $display("lfu_page_cache_directory_top_tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
design/lfu_pcd_pkg.sv
design/lfu_pcd_cell.sv
design/lfu_pcd_top.sv
dv/lfu_page_cache_directory_checker.sv
dv/lfu_page_cache_directory_top_tb.sv
